>>> hw/rtl/effect_pool_aging_allocator_core_assert.svh
// Assertion macros for the effect pool allocator.
// Used by the top level; needs no package.
`ifndef EFFECT_POOL_AGING_ALLOCATOR_CORE_ASSERT_SVH
`define EFFECT_POOL_AGING_ALLOCATOR_CORE_ASSERT_SVH

// condition a implies condition c in the same cycle
`define EPAA_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("epaa assertion failed");

// condition a implies condition c in the next cycle
`define EPAA_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("epaa assertion failed");

`endif

>>> hw/rtl/epaa_pkg.sv
// Shared types and constants for the effect pool allocator.
// No dependencies.
package epaa_pkg;

  localparam int POOL_DEPTH_DEF = 8;

  localparam int DIV_W   = 56;
  localparam int STEP_W  = 6;
  localparam int REM_W   = 24;
  localparam int PAY_W   = 120;
  localparam int AGE_W   = 32;

  localparam logic [9:0]  SCALE_MIN = 10'd90;
  localparam logic [9:0]  SCALE_MAX = 10'd640;
  localparam logic [9:0]  SCALE_ONE = 10'd256;
  localparam logic [23:0] SIZE_MAX  = 24'hFFFFFF;

  localparam logic [2:0] CFG_LIFE_DURATION  = 3'd0;
  localparam logic [2:0] CFG_REFERENCE_SPAN = 3'd1;
  localparam logic [2:0] CFG_START_RADIUS   = 3'd2;
  localparam logic [2:0] CFG_END_RADIUS     = 3'd3;
  localparam logic [2:0] CFG_RISE_DISTANCE  = 3'd4;
  localparam logic [2:0] CFG_SPAWN_ENABLED  = 3'd5;

  localparam logic [STEP_W-1:0] STEPS_SCALE  = 6'd25;
  localparam logic [STEP_W-1:0] STEPS_FRAC   = 6'd16;
  localparam logic [STEP_W-1:0] STEPS_RADIUS = 6'd56;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SP_DIV,
    ST_SP_WAIT,
    ST_SP_MUL,
    ST_SP_OUT,
    ST_AG_RD,
    ST_AG_WR,
    ST_EM_SEL,
    ST_EM_FR,
    ST_EM_FWAIT,
    ST_EM_M1,
    ST_EM_M2,
    ST_EM_M3,
    ST_EM_M4,
    ST_EM_RWAIT,
    ST_EM_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [REM_W-1:0]  rem_init;
    logic [DIV_W-1:0]  num;
    logic [REM_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

>>> hw/rtl/epaa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module epaa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/epaa_div.sv
// Restoring divider, one quotient bit per cycle, shared by scale,
// life fraction and radius rescale. Depends on epaa_pkg.
module epaa_div import epaa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  den;
  logic [DIV_W-1:0]  numsh;
  logic [DIV_W-1:0]  q;
  logic [REM_W:0]    trial;
  logic              ge;
  logic [REM_W-1:0]  rem_next;

  always_comb begin
    trial    = {rem, numsh[DIV_W-1]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? REM_W'(trial - {1'b0, den}) : trial[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= req.rem_init;
      den   <= req.den;
      numsh <= req.num;
      q     <= '0;
    end else if (busy) begin
      rem   <= rem_next;
      numsh <= {numsh[DIV_W-2:0], 1'b0};
      q     <= {q[DIV_W-2:0], ge};
    end
  end

  assign quo = q;

endmodule

>>> hw/rtl/effect_pool_aging_allocator_core.sv
// Spawn: with a free slot and a nonzero reference span, a scale division
// runs; a zero span skips it; when the pool is full an oldest-slot scan
// comes first.
// Advance: an aging pass over every slot, then for each surviving slot a
// life-fraction division and, with radius rescale, a second division;
// expired slots report without a division. Output stalls hold the results.
// One item at a time; input stalls outside idle. Reset clears live bits and
// control; age and payload memories are not cleared.
`include "effect_pool_aging_allocator_core_assert.svh"
module effect_pool_aging_allocator_core import epaa_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] spawn_x,
  input  logic signed [31:0] spawn_y,
  input  logic signed [31:0] spawn_z,
  input  logic [15:0]        span_cm,
  input  logic [15:0]        delta_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         slot,
  output logic               visible,
  output logic [23:0]        radius_q8,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [15:0]        life_fraction,
  output logic [3:0]         live_count,
  output logic               last
);

  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_DEPTH - 1);

  // configuration
  logic [23:0] life_duration;
  logic [15:0] reference_span;
  logic [15:0] start_radius;
  logic [15:0] end_radius;
  logic [15:0] rise_distance;
  logic        spawn_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      life_duration  <= 24'd2048;
      reference_span <= 16'd3600;
      start_radius   <= 16'd100;
      end_radius     <= 16'd400;
      rise_distance  <= 16'd200;
      spawn_enabled  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIFE_DURATION:  life_duration  <= cfg_data;
        CFG_REFERENCE_SPAN: reference_span <= cfg_data[15:0];
        CFG_START_RADIUS:   start_radius   <= cfg_data[15:0];
        CFG_END_RADIUS:     end_radius     <= cfg_data[15:0];
        CFG_RISE_DISTANCE:  rise_distance  <= cfg_data[15:0];
        CFG_SPAWN_ENABLED:  spawn_enabled  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  logic [POOL_DEPTH-1:0] live;
  logic [POOL_DEPTH-1:0] report;
  logic [POOL_DEPTH-1:0] expd;
  logic [CW-1:0]         live_cnt;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         idx_inc;
  logic [IW-1:0]         spawn_slot;
  logic                  stolen;
  logic [AGE_W-1:0]      best_age;

  logic [31:0] in_x, in_y, in_z;
  logic [15:0] in_span, in_dt;

  logic [9:0]  scale;
  logic [23:0] size_r;
  logic [AGE_W-1:0] age_rd;
  logic [PAY_W-1:0] pay_rd;
  logic [PAY_W-1:0] pay_r;
  logic [15:0] frac;
  logic [32:0] m1;
  logic [31:0] lerp;
  logic [55:0] prod;
  logic [15:0] zr;
  logic [31:0] z_r;
  logic [23:0] rad;

  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  div_req_t         div_req;

  logic             accept;
  logic             can_load;
  logic             any_free;
  logic [IW-1:0]    free_idx;
  logic [AGE_W:0]   age_sum;
  logic [AGE_W-1:0] age_new;
  logic             age_exp;
  logic [POOL_DEPTH-1:0] rep_rest;
  logic             emit;
  logic             age_we;
  logic [IW-1:0]    age_waddr;
  logic [AGE_W-1:0] age_wdata;
  logic             pay_we;
  logic [24:0]      scale_num;
  logic [9:0]       scale_clamped;
  logic [25:0]      size_full;
  logic [32:0]      zsum;
  logic [IW+2:0]    idx_ext;
  logic [IW+2:0]    spawn_ext;
  logic [CW-1:0]    spawn_cnt;
  logic             div_wait;

  assign accept   = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;
  assign idx_inc  = (idx == LAST_IDX) ? '0 : idx + 1'b1;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (!live[i]) begin
        any_free = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    rep_rest      = report;
    rep_rest[idx] = 1'b0;
  end

  always_comb begin
    age_sum   = {1'b0, age_rd} + (AGE_W + 1)'(in_dt);
    age_new   = age_sum[AGE_W] ? '1 : age_sum[AGE_W-1:0];
    age_exp   = age_new >= AGE_W'(life_duration);
    scale_num = {1'b0, in_span, 8'b0} + 25'(reference_span >> 1);
    if (div_quo < DIV_W'(SCALE_MIN)) begin
      scale_clamped = SCALE_MIN;
    end else if (div_quo > DIV_W'(SCALE_MAX)) begin
      scale_clamped = SCALE_MAX;
    end else begin
      scale_clamped = div_quo[9:0];
    end
    size_full = start_radius * scale;
    zsum      = {pay_r[55], pay_r[55:24]} + {17'b0, zr};
    spawn_cnt = stolen ? live_cnt : live_cnt + 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!mode) begin
            if (!spawn_enabled) state_next = ST_IDLE;
            else if (any_free)  state_next = ST_SP_DIV;
            else                state_next = ST_SCAN_RD;
          end else if (life_duration != '0 && live_cnt != '0) begin
            state_next = ST_AG_RD;
          end
        end
      end
      ST_SCAN_RD:  state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: state_next = (idx == LAST_IDX) ? ST_SP_DIV : ST_SCAN_RD;
      ST_SP_DIV:   state_next = (reference_span == '0) ? ST_SP_MUL : ST_SP_WAIT;
      ST_SP_WAIT:  if (div_done) state_next = ST_SP_MUL;
      ST_SP_MUL:   state_next = ST_SP_OUT;
      ST_SP_OUT:   if (can_load) state_next = ST_IDLE;
      ST_AG_RD: begin
        if (live[idx])              state_next = ST_AG_WR;
        else if (idx == LAST_IDX)   state_next = ST_EM_SEL;
      end
      ST_AG_WR:    state_next = (idx == LAST_IDX) ? ST_EM_SEL : ST_AG_RD;
      ST_EM_SEL: begin
        if (report == '0)                   state_next = ST_IDLE;
        else if (report[idx] && !expd[idx]) state_next = ST_EM_FR;
      end
      ST_EM_FR:    state_next = ST_EM_FWAIT;
      ST_EM_FWAIT: if (div_done) state_next = ST_EM_M1;
      ST_EM_M1:    state_next = ST_EM_M2;
      ST_EM_M2:    state_next = ST_EM_M3;
      ST_EM_M3:    state_next = ST_EM_M4;
      ST_EM_M4: begin
        if (reference_span != '0 && start_radius != '0) state_next = ST_EM_RWAIT;
        else                                              state_next = ST_EM_OUT;
      end
      ST_EM_RWAIT: if (div_done) state_next = ST_EM_OUT;
      ST_EM_OUT:   if (can_load) state_next = ST_EM_SEL;
      default:     state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    emit      = 1'b0;
    age_we    = 1'b0;
    age_waddr = idx;
    age_wdata = age_new;
    pay_we    = 1'b0;
    div_req   = '0;
    unique case (state)
      ST_SP_DIV: begin
        div_req.start = (reference_span != '0);
        div_req.num   = {scale_num, 31'b0};
        div_req.den   = {8'b0, reference_span};
        div_req.steps = STEPS_SCALE;
      end
      ST_SP_OUT: begin
        emit      = can_load;
        age_we    = can_load;
        age_waddr = spawn_slot;
        age_wdata = '0;
        pay_we    = can_load;
      end
      ST_AG_WR: age_we = 1'b1;
      ST_EM_SEL: emit = report[idx] && expd[idx] && can_load;
      ST_EM_FR: begin
        div_req.start    = 1'b1;
        div_req.rem_init = age_rd[REM_W-1:0];
        div_req.den      = life_duration;
        div_req.steps    = STEPS_FRAC;
      end
      ST_EM_M4: begin
        div_req.start = (reference_span != '0 && start_radius != '0);
        div_req.num   = prod;
        div_req.den   = {8'b0, start_radius};
        div_req.steps = STEPS_RADIUS;
      end
      ST_EM_OUT: emit = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      live     <= '0;
      report   <= '0;
      expd     <= '0;
      live_cnt <= '0;
      idx      <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: idx <= '0;
        ST_SCAN_CMP: idx <= idx_inc;
        ST_SP_OUT: begin
          if (can_load) begin
            live[spawn_slot] <= 1'b1;
            live_cnt         <= spawn_cnt;
          end
        end
        ST_AG_RD: if (!live[idx]) idx <= idx_inc;
        ST_AG_WR: begin
          report[idx] <= 1'b1;
          if (age_exp) begin
            expd[idx] <= 1'b1;
            live[idx] <= 1'b0;
            live_cnt  <= live_cnt - 1'b1;
          end
          idx <= idx_inc;
        end
        ST_EM_SEL: begin
          if (!report[idx]) begin
            idx <= idx_inc;
          end else if (expd[idx] && can_load) begin
            report[idx] <= 1'b0;
            expd[idx]   <= 1'b0;
            idx         <= idx_inc;
          end
        end
        ST_EM_OUT: begin
          if (can_load) begin
            report[idx] <= 1'b0;
            idx         <= idx_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_x       <= spawn_x;
      in_y       <= spawn_y;
      in_z       <= spawn_z;
      in_span    <= span_cm;
      in_dt      <= delta_time;
      spawn_slot <= free_idx;
      stolen     <= !any_free;
    end
    if (state == ST_SCAN_CMP && (idx == '0 || age_rd > best_age)) begin
      best_age   <= age_rd;
      spawn_slot <= idx;
    end
    if (state == ST_SP_DIV)                 scale <= SCALE_ONE;
    if (state == ST_SP_WAIT && div_done)    scale <= scale_clamped;
    if (state == ST_SP_MUL) begin
      size_r <= (size_full > 26'(SIZE_MAX)) ? SIZE_MAX : size_full[23:0];
    end
    if (state == ST_EM_FR)                  pay_r <= pay_rd;
    if (state == ST_EM_FWAIT && div_done)   frac <= div_quo[15:0];
    if (state == ST_EM_M1) m1 <= start_radius * ({1'b1, 16'b0} - {1'b0, frac});
    if (state == ST_EM_M2) lerp <= 32'(m1 + 33'(end_radius) * 33'(frac));
    if (state == ST_EM_M3) begin
      prod <= lerp * pay_r[23:0];
      zr   <= 16'((32'(rise_distance) * 32'(frac)) >> 16);
    end
    if (state == ST_EM_M4) begin
      z_r <= (!zsum[32] && zsum[31]) ? 32'h7FFFFFFF : zsum[31:0];
      rad <= lerp[31:8];
    end
    if (state == ST_EM_RWAIT && div_done) begin
      rad <= (div_quo[55:40] != '0) ? SIZE_MAX : div_quo[39:16];
    end
  end

  // result register
  assign idx_ext   = (IW + 3)'(idx);
  assign spawn_ext = (IW + 3)'(spawn_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      priority if (state == ST_SP_OUT) begin
        slot          <= spawn_ext[2:0];
        visible       <= 1'b1;
        radius_q8     <= size_r;
        out_x         <= in_x;
        out_y         <= in_y;
        out_z         <= in_z;
        life_fraction <= '0;
        live_count    <= 4'(spawn_cnt);
        last          <= 1'b1;
      end else if (state == ST_EM_OUT) begin
        slot          <= idx_ext[2:0];
        visible       <= 1'b1;
        radius_q8     <= rad;
        out_x         <= pay_r[119:88];
        out_y         <= pay_r[87:56];
        out_z         <= z_r;
        life_fraction <= frac;
        live_count    <= 4'(live_cnt);
        last          <= (rep_rest == '0);
      end else begin
        slot          <= idx_ext[2:0];
        visible       <= 1'b0;
        radius_q8     <= '0;
        out_x         <= '0;
        out_y         <= '0;
        out_z         <= '0;
        life_fraction <= '0;
        live_count    <= 4'(live_cnt);
        last          <= (rep_rest == '0);
      end
    end
  end

  epaa_ram #(.WIDTH(AGE_W), .DEPTH(POOL_DEPTH)) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_wdata),
    .raddr (idx),
    .rdata (age_rd)
  );

  epaa_ram #(.WIDTH(PAY_W), .DEPTH(POOL_DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (spawn_slot),
    .wdata ({in_x, in_y, in_z, size_r}),
    .raddr (idx),
    .rdata (pay_rd)
  );

  epaa_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  assign div_wait = (state == ST_SP_WAIT) || (state == ST_EM_FWAIT) ||
                    (state == ST_EM_RWAIT);

  `EPAA_ASSERT_IMPLY(a_live_cnt, clk, rst, 1'b1, live_cnt == CW'($countones(live)))
  `EPAA_ASSERT_IMPLY(a_exp_dead, clk, rst, 1'b1, (expd & live) == '0)
  `EPAA_ASSERT_IMPLY(a_div_done, clk, rst, div_done, div_wait)
  `EPAA_ASSERT_NEXT(a_emit_valid, clk, rst, emit, out_valid)

endmodule

>>> sim/effect_pool_checker.sv
// Checker for the effect pool allocator: tracks register writes, predicts every
// result of each accepted item and compares the results in order.
// Depends on epaa_pkg for the register indexes.
module effect_pool_checker import epaa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] spawn_x,
  input  logic signed [31:0] spawn_y,
  input  logic signed [31:0] spawn_z,
  input  logic [15:0]        span_cm,
  input  logic [15:0]        delta_time,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         slot,
  input  logic               visible,
  input  logic [23:0]        radius_q8,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic [15:0]        life_fraction,
  input  logic [3:0]         live_count,
  input  logic               last,
  output int                 pending,
  output int                 fail_count,
  output int                 checked
);

  localparam int DEPTH = 8;

  typedef struct {
    logic [2:0]  slot;
    logic        visible;
    logic [23:0] radius;
    logic [31:0] x, y, z;
    logic [15:0] frac;
    logic [3:0]  live;
    logic        last;
  } pool_report_t;

  pool_report_t pool_reports[$];

  logic [23:0] life_dur;
  logic [15:0] ref_span, rad_start, rad_end, rise;
  logic        spawn_en;

  logic        slot_live[DEPTH];
  logic [31:0] slot_age[DEPTH];
  logic [31:0] org_x[DEPTH], org_y[DEPTH], org_z[DEPTH];
  logic [23:0] birth_rad[DEPTH];

  assign pending = pool_reports.size();

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  function automatic int count_live();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) if (slot_live[i]) n++;
    return n;
  endfunction

  task automatic spawn_entry();
    int          s;
    logic [31:0] oldest;
    logic [63:0] scale, size;
    pool_report_t r;
    s = -1;
    oldest = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!slot_live[i]) begin
        s = i;
        break;
      end
    end
    if (s < 0) begin
      // every slot live: steal the oldest, lowest index on ties
      s = 0;
      oldest = slot_age[0];
      for (int i = 1; i < DEPTH; i++)
        if (slot_age[i] > oldest) begin
          oldest = slot_age[i];
          s = i;
        end
    end
    scale = 256;
    if (ref_span != 0) begin
      scale = (64'(span_cm) * 256 + 64'(ref_span / 2)) / 64'(ref_span);
      if (scale < 90) scale = 90;
      if (scale > 640) scale = 640;
    end
    size = 64'(rad_start) * scale;
    if (size > 64'hFFFFFF) size = 64'hFFFFFF;
    slot_age[s] = 0;
    org_x[s] = spawn_x;
    org_y[s] = spawn_y;
    org_z[s] = spawn_z;
    birth_rad[s] = size[23:0];
    slot_live[s] = 1'b1;
    r = '{3'(s), 1'b1, size[23:0], spawn_x, spawn_y, spawn_z, 16'd0, 4'(count_live()), 1'b1};
    pool_reports.push_back(r);
  endtask

  task automatic advance_pool();
    pool_report_t batch[$];
    pool_report_t r;
    logic [63:0] age, f, lerp, rad;
    logic signed [63:0] zs;
    if (life_dur == 0) return;
    for (int i = 0; i < DEPTH; i++) begin
      if (!slot_live[i]) continue;
      age = 64'(slot_age[i]) + 64'(delta_time);
      if (age > 64'hFFFFFFFF) age = 64'hFFFFFFFF;
      slot_age[i] = age[31:0];
      if (age >= 64'(life_dur)) begin
        slot_live[i] = 1'b0;
        r = '{3'(i), 1'b0, 24'd0, 32'd0, 32'd0, 32'd0, 16'd0, 4'd0, 1'b0};
      end else begin
        f = (age << 16) / 64'(life_dur);
        lerp = 64'(rad_start) * (64'd65536 - f) + 64'(rad_end) * f;
        if (ref_span != 0 && rad_start != 0)
          rad = lerp * 64'(birth_rad[i]) / (64'(rad_start) << 16);
        else
          rad = lerp >> 8;
        if (rad > 64'hFFFFFF) rad = 64'hFFFFFF;
        zs = $signed({{32{org_z[i][31]}}, org_z[i]}) + $signed((64'(rise) * f) >> 16);
        if (zs > 64'sh7FFFFFFF) zs = 64'sh7FFFFFFF;
        r = '{3'(i), 1'b1, rad[23:0], org_x[i], org_y[i], zs[31:0], f[15:0], 4'd0, 1'b0};
      end
      batch.push_back(r);
    end
    foreach (batch[k]) begin
      batch[k].live = 4'(count_live());
      batch[k].last = (k == batch.size() - 1);
      pool_reports.push_back(batch[k]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      life_dur  = 24'd2048;
      ref_span  = 16'd3600;
      rad_start = 16'd100;
      rad_end   = 16'd400;
      rise      = 16'd200;
      spawn_en  = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
        slot_live[i] = 1'b0;
        slot_age[i]  = 0;
      end
      pool_reports.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIFE_DURATION:  life_dur  = cfg_data;
          CFG_REFERENCE_SPAN: ref_span  = cfg_data[15:0];
          CFG_START_RADIUS:   rad_start = cfg_data[15:0];
          CFG_END_RADIUS:     rad_end   = cfg_data[15:0];
          CFG_RISE_DISTANCE:  rise      = cfg_data[15:0];
          CFG_SPAWN_ENABLED:  spawn_en  = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        pool_report_t e;
        if (pool_reports.size() == 0) begin
          report_mismatch("unexpected result slot", 32'(slot), 32'hX);
        end else begin
          e = pool_reports.pop_front();
          checked++;
          if (slot !== e.slot) report_mismatch("slot", 32'(slot), 32'(e.slot));
          if (visible !== e.visible) report_mismatch("visible", 32'(visible), 32'(e.visible));
          if (radius_q8 !== e.radius) report_mismatch("radius_q8", 32'(radius_q8), 32'(e.radius));
          if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
          if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
          if (out_z !== e.z) report_mismatch("out_z", out_z, e.z);
          if (life_fraction !== e.frac)
            report_mismatch("life_fraction", 32'(life_fraction), 32'(e.frac));
          if (live_count !== e.live) report_mismatch("live_count", 32'(live_count), 32'(e.live));
          if (last !== e.last) report_mismatch("last", 32'(last), 32'(e.last));
        end
      end
      if (in_valid && !in_stall) begin
        if (mode == 1'b0) begin
          if (spawn_en) spawn_entry();
        end else begin
          advance_pool();
        end
      end
    end
  end

endmodule

>>> sim/tb.sv
// Testbench top for effect_pool_aging_allocator_core: clock, reset, register
// phases and item stimulus; effect_pool_checker checks every result.
// Depends on epaa_pkg, the core and effect_pool_checker.
module tb import epaa_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_LIFE_DURATION;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic signed [31:0] spawn_x = '0, spawn_y = '0, spawn_z = '0;
  logic [15:0] span_cm = '0, delta_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] slot;
  logic visible, last;
  logic [23:0] radius_q8;
  logic signed [31:0] out_x, out_y, out_z;
  logic [15:0] life_fraction;
  logic [3:0] live_count;

  int pending, fail_count, checked;
  int items_sent = 0;
  int stall_left = 0;
  logic quiet = 1'b0;
  logic [23:0] cur_life = 24'd2048;

  always #5 clk = ~clk;

  effect_pool_aging_allocator_core dut (.*);

  effect_pool_checker chk (.*);

  // random receiver stall bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(logic m, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [15:0] span, logic [15:0] dt);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    spawn_x <= x;
    spawn_y <= y;
    spawn_z <= z;
    span_cm <= span;
    delta_time <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic random_item();
    logic [31:0] x, y, z, lim;
    logic [15:0] span, dt;
    x = $urandom;
    y = $urandom;
    z = $urandom;
    case ($urandom_range(0, 7))
      0: z = 32'h7FFFFFF0;
      1: x = 32'h80000000;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: span = 16'($urandom);
      1: span = 16'hFFFF;
      default: span = 16'($urandom_range(0, 8000));
    endcase
    lim = (cur_life / 3) + 1;
    if (lim > 65535) lim = 65535;
    case ($urandom_range(0, 9))
      0: dt = 16'hFFFF;
      1: dt = 16'd0;
      default: dt = 16'($urandom_range(0, lim));
    endcase
    send_item(1'($urandom_range(0, 1)), x, y, z, span, dt);
  endtask

  // hold the write enable; the caller drops it after the last write
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // drain, then cover an advance that is still walking slots without results
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic set_regs(logic [23:0] life, logic [15:0] rspan, logic [15:0] rs,
                          logic [15:0] re, logic [15:0] rd, logic en);
    settle();
    write_reg(CFG_LIFE_DURATION, life);
    write_reg(CFG_REFERENCE_SPAN, 24'(rspan));
    write_reg(CFG_START_RADIUS, 24'(rs));
    write_reg(CFG_END_RADIUS, 24'(re));
    write_reg(CFG_RISE_DISTANCE, 24'(rd));
    write_reg(CFG_SPAWN_ENABLED, 24'(en));
    cfg_we <= 1'b0;
    cur_life = life;
  endtask

  initial begin
    #20_000_000;
    $display("effect_pool_aging_allocator_core test failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, span clamps, full pool and oldest steal
    send_item(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 16'd3600, 16'd0);
    send_item(1'b0, 32'h0, 32'hFFFFFFFF, 32'h80000000, 16'd0, 16'hFFFF);
    send_item(1'b0, 32'h1, 32'h2, 32'h7FFFFFFF, 16'hFFFF, 16'd0);
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 16'd0, 16'd0);
    send_item(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'd100);
    for (int i = 0; i < 5; i++)
      send_item(1'b0, $urandom, $urandom, $urandom, 16'($urandom_range(0, 9000)), 16'd0);
    send_item(1'b0, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'h7FFFFF00, 16'd1800, 16'd0);
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 16'd0, 16'd500);
    send_item(1'b0, 32'h12345678, 32'h9ABCDEF0, 32'h7FFFFFFF, 16'd7200, 16'd0);
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 16'd0, 16'd1000);
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 16'd0, 16'hFFFF);
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 16'd0, 16'd1);

    // any nonzero delta expires every slot; unit scale and zero start radius
    set_regs(24'd1, 16'd0, 16'd0, 16'hFFFF, 16'd0, 1'b1);
    repeat (15) random_item();
    // longest life, saturated birth radius, largest rise
    set_regs(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
    repeat (20) random_item();
    // aging and spawning both off: no results at all
    set_regs(24'd0, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
    repeat (10) random_item();
    set_regs(24'($urandom_range(500, 60000)), 16'($urandom_range(1, 65535)),
             16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom), 1'b1);
    repeat (20) random_item();
    set_regs(24'd2048, 16'd3600, 16'd100, 16'd400, 16'd200, 1'b1);
    repeat (15) random_item();
    quiet <= 1'b1;
    repeat (20) random_item();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    $display("sent %0d items through six register settings", items_sent);
    $display("compared %0d results field by field", checked);
    if (fail_count == 0) begin
      $display("effect_pool_aging_allocator_core test passed");
    end else begin
      $display("effect_pool_aging_allocator_core test failed");
    end
    $finish;
  end

endmodule

>>> effect_pool_aging_allocator_core.f
+incdir+hw/rtl
hw/rtl/epaa_pkg.sv
hw/rtl/epaa_ram.sv
hw/rtl/epaa_div.sv
hw/rtl/effect_pool_aging_allocator_core.sv
sim/effect_pool_checker.sv
sim/tb.sv
